// ===== design/assert_macros.svh =====
// Assertion helpers shared by the formatter modules.
// Both macros sample on the rising clock edge and stay quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define PIF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The expression must never be true at a sampled edge.
`define PIF_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== design/pif_pkg.sv =====
// ----------------------------------------------------------------------------
// pif_pkg
// Types, character codes and elaboration helpers for the integer formatter.
// ----------------------------------------------------------------------------
package pif_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] CH_XL      = 8'h78;
   localparam logic [7:0] CH_XU      = 8'h58;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_A_LOW   = 8'h61;
   localparam logic [7:0] CH_A_UP    = 8'h41;

   typedef enum logic {
      CMD_ECHO,
      CMD_FORMAT
   } cmd_kind_type;

   typedef enum logic [1:0] {
      CONV_DEC_S,
      CONV_DEC_U,
      CONV_HEX_L,
      CONV_HEX_U
   } conv_type;

   typedef struct packed {
      cmd_kind_type kind;
      conv_type     conv;
      logic         zero_pad;
      logic [3:0]   field_width;
      logic [7:0]   char_code;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   // Number of decimal positions needed for a word of the given width.
   function automatic int dec_digits(input int bits);
      logic [63:0] mask;
      logic [63:0] order;
      int          n;
      mask  = (64'd1 << bits) - 64'd1;
      order = 64'd1;
      n     = 1;
      for (int i = 0; i < 20; i++) begin
         if (order * 64'd10 <= mask) begin
            order = order * 64'd10;
            n     = n + 1;
         end
      end
      return n;
   endfunction

   // Ten to the power n, evaluated at elaboration.
   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < 20; i++) begin
         if (i < n) begin
            p = p * 64'd10;
         end
      end
      return p;
   endfunction

endpackage

// ===== design/printf_integer_formatter.sv =====
// ----------------------------------------------------------------------------
// printf_integer_formatter
// Character-serial printf engine for %d, %u, %x and %X conversions.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                              | tuser     | tlast
//  req_     | in        | char_code[7:0], argument[39:8]     | operation | -
//  rsp_     | out       | out_char[7:0]                      | -         | last
//
// The parser takes one item per cycle while its two-entry command queue has room.
// An echoed or passed-through character goes straight into the output register; a conversion
// is loaded, then the digit walker visits each digit position (10 decimal or 8 hex at 32 bits)
// from the most significant down, and may revisit one position to put out a minus sign.
// Reset is synchronous and clears the parser flags, the queue pointers, the walker state and the output valid flag.
// A low rsp_tready holds the output register and the walker; the queue keeps the parser
// taking items until it fills.
module printf_integer_formatter #(
   parameter int ARG_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // operation
   input  logic [39:0] req_tdata,   // char_code[7:0], argument[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_char
   output logic        rsp_tlast    // last
);
   import pif_pkg::*;

   logic                push, full, pop, q_valid;
   cmd_type             push_cmd, head_cmd;
   logic [ARG_BITS-1:0] push_arg, head_arg;

   pif_front #(.ARG_BITS(ARG_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (full),
      .q_push     (push),
      .q_cmd      (push_cmd),
      .q_arg      (push_arg)
   );

   pif_queue #(.ARG_BITS(ARG_BITS)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .push_arg (push_arg),
      .full     (full),
      .pop      (pop),
      .valid    (q_valid),
      .head_cmd (head_cmd),
      .head_arg (head_arg)
   );

   pif_back #(.ARG_BITS(ARG_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_arg      (head_arg),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/pif_front.sv =====
// ----------------------------------------------------------------------------
// pif_front
// Parses format characters, tracks the conversion flags and queues work.
// ----------------------------------------------------------------------------
module pif_front #(
   parameter int ARG_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // operation
   input  logic [39:0]           req_tdata,   // char_code[7:0], argument[39:8]
   input  logic                  q_full,
   output logic                  q_push,
   output pif_pkg::cmd_type      q_cmd,
   output logic [ARG_BITS-1:0]   q_arg
);
   import pif_pkg::*;

   logic       in_conv_ff, in_conv_in;
   logic       zero_pad_ff, zero_pad_in;
   logic [3:0] width_ff, width_in;
   logic [7:0] char_code;
   logic       accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign char_code  = req_tdata[7:0];
   assign q_arg      = req_tdata[8 +: ARG_BITS];

   always_comb begin
      in_conv_in        = in_conv_ff;
      zero_pad_in       = zero_pad_ff;
      width_in          = width_ff;
      q_push            = 1'b0;
      q_cmd.kind        = CMD_ECHO;
      q_cmd.conv        = CONV_DEC_S;
      q_cmd.zero_pad    = zero_pad_ff;
      q_cmd.field_width = width_ff;
      q_cmd.char_code   = char_code;
      if (accept) begin
         if (req_tuser) begin
            q_push = 1'b1;
         end else if (char_code == CH_PERCENT) begin
            in_conv_in  = 1'b1;
            zero_pad_in = 1'b0;
            width_in    = 4'd0;
         end else if (in_conv_ff) begin
            if (char_code == CH_ZERO) begin
               zero_pad_in = 1'b1;
            end else if (char_code inside {[CH_ONE:CH_NINE]}) begin
               width_in = char_code[3:0];
            end else begin
               // Any other character closes the conversion; unknown ones say nothing.
               in_conv_in = 1'b0;
               q_cmd.kind = CMD_FORMAT;
               case (char_code)
                  CH_D: begin
                     q_push     = 1'b1;
                     q_cmd.conv = CONV_DEC_S;
                  end
                  CH_U: begin
                     q_push     = 1'b1;
                     q_cmd.conv = CONV_DEC_U;
                  end
                  CH_XL: begin
                     q_push     = 1'b1;
                     q_cmd.conv = CONV_HEX_L;
                  end
                  CH_XU: begin
                     q_push     = 1'b1;
                     q_cmd.conv = CONV_HEX_U;
                  end
                  default: begin
                     q_push = 1'b0;
                  end
               endcase
            end
         end else begin
            q_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_conv_ff  <= 1'b0;
         zero_pad_ff <= 1'b0;
         width_ff    <= 4'd0;
      end else begin
         in_conv_ff  <= in_conv_in;
         zero_pad_ff <= zero_pad_in;
         width_ff    <= width_in;
      end
   end

endmodule

// ===== design/pif_queue.sv =====
// ----------------------------------------------------------------------------
// pif_queue
// Two-entry queue of parsed commands between the parser and the digit walker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pif_queue #(
   parameter int ARG_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pif_pkg::cmd_type      push_cmd,
   input  logic [ARG_BITS-1:0]   push_arg,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output pif_pkg::cmd_type      head_cmd,
   output logic [ARG_BITS-1:0]   head_arg
);
   import pif_pkg::*;

   cmd_type             cmd_ff [2];
   logic [ARG_BITS-1:0] arg_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign valid    = (cnt_ff != 2'd0);
   assign head_cmd = cmd_ff[rd_ptr_ff];
   assign head_arg = arg_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= push_cmd;
         arg_ff[wr_ptr_ff] <= push_arg;
      end
   end

   `PIF_NEVER(a_q_push_full, push && full, "command written into a full queue")
   `PIF_NEVER(a_q_pop_empty, pop && !valid, "command taken from an empty queue")
   `PIF_NEVER(a_q_count, cnt_ff == 2'd3, "queue count out of range")

endmodule

// ===== design/pif_back.sv =====
// ----------------------------------------------------------------------------
// pif_back
// Walks the digit positions of a conversion and drives the character stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pif_back #(
   parameter int ARG_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  pif_pkg::cmd_type      q_cmd,
   input  logic [ARG_BITS-1:0]   q_arg,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // out_char
   output logic                  rsp_tlast    // last
);
   import pif_pkg::*;

   localparam int DEC_POS  = dec_digits(ARG_BITS);
   localparam int HEX_POS  = (ARG_BITS + 3) / 4;
   localparam int VAL_BITS = 4 * HEX_POS;
   localparam int POS_BITS = $clog2(DEC_POS + 1);
   localparam int DIDX     = $clog2(DEC_POS);
   localparam int HIDX     = $clog2(HEX_POS);
   localparam int MW       = ARG_BITS + 4;
   localparam int WCMP     = POS_BITS + 4;

   back_state_type      state_ff, state_in;
   logic [VAL_BITS-1:0] val_ff, val_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                neg_ff, neg_in;
   logic                printed_ff, printed_in;
   logic                hex_ff, hex_in;
   logic                upper_ff, upper_in;
   logic                zpad_ff, zpad_in;
   logic [3:0]          width_ff, width_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_char_ff;
   logic                out_last_ff;

   // Multiples k * 10^p for k = 1..9; entry [p][k-1].
   logic [MW-1:0]       mult_tab [DEC_POS][9];
   logic [3:0]          nib [HEX_POS];

   logic                out_en;
   logic                emit, emit_last, start, done;
   logic [7:0]          emit_char;
   logic [DIDX-1:0]     pi, pi_next;
   logic [HIDX-1:0]     hidx, hnext;
   logic [ARG_BITS-1:0] dec_v, dec_sub, arg_neg;
   logic [3:0]          dec_d, dig;
   logic                next_nz;
   logic [7:0]          letter, dig_char;
   logic                arg_is_neg;

   for (genvar p = 0; p < DEC_POS; p++) begin : g_pow
      for (genvar k = 0; k < 9; k++) begin : g_mult
         assign mult_tab[p][k] = MW'(pow10(p) * 64'(k + 1));
      end
   end

   for (genvar i = 0; i < HEX_POS; i++) begin : g_nib
      assign nib[i] = val_ff[4 * i +: 4];
   end

   assign out_en  = !out_valid_ff || rsp_tready;
   assign pi      = DIDX'(pos_ff - 1'b1);
   assign pi_next = pi - 1'b1;
   assign hidx    = pi[HIDX-1:0];
   assign hnext   = hidx - 1'b1;
   assign dec_v   = val_ff[ARG_BITS-1:0];
   assign arg_neg = ~q_arg + 1'b1;
   assign arg_is_neg = (q_cmd.conv == CONV_DEC_S) && q_arg[ARG_BITS-1];

   // Decimal digit by comparison against all nine multiples of this position.
   always_comb begin
      dec_d   = 4'd0;
      dec_sub = '0;
      for (int k = 0; k < 9; k++) begin
         if ({4'd0, dec_v} >= mult_tab[pi][k]) begin
            dec_d   = 4'(k + 1);
            dec_sub = mult_tab[pi][k][ARG_BITS-1:0];
         end
      end
   end

   always_comb begin
      dig    = hex_ff ? nib[hidx] : dec_d;
      letter = upper_ff ? CH_A_UP : CH_A_LOW;
      if (dig > 4'd9) begin
         dig_char = 8'(dig) - 8'd10 + letter;
      end else begin
         dig_char = 8'(dig) + CH_ZERO;
      end
      // Only used on a leading zero position, where the value is unchanged.
      if (pos_ff > POS_BITS'(1)) begin
         next_nz = hex_ff ? (nib[hnext] != 4'd0) : ({4'd0, dec_v} >= mult_tab[pi_next][0]);
      end else begin
         next_nz = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (done) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_char  = q_cmd.char_code;
      start      = 1'b0;
      done       = 1'b0;
      q_pop      = 1'b0;
      val_in     = val_ff;
      pos_in     = pos_ff;
      neg_in     = neg_ff;
      printed_in = printed_ff;
      hex_in     = hex_ff;
      upper_in   = upper_ff;
      zpad_in    = zpad_ff;
      width_in   = width_ff;
      case (state_ff)
         BK_IDLE: begin
            if (out_en && q_valid) begin
               q_pop = 1'b1;
               if (q_cmd.kind == CMD_ECHO) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
               end else begin
                  start      = 1'b1;
                  hex_in     = (q_cmd.conv == CONV_HEX_L) || (q_cmd.conv == CONV_HEX_U);
                  upper_in   = (q_cmd.conv == CONV_HEX_U);
                  zpad_in    = q_cmd.zero_pad;
                  width_in   = q_cmd.field_width;
                  printed_in = 1'b0;
                  neg_in     = arg_is_neg;
                  val_in     = VAL_BITS'(arg_is_neg ? arg_neg : q_arg);
                  if (hex_in) begin
                     pos_in = POS_BITS'(HEX_POS);
                  end else begin
                     pos_in = POS_BITS'(DEC_POS);
                  end
               end
            end
         end
         BK_RUN: begin
            if (out_en) begin
               if (printed_ff || (dig != 4'd0)) begin
                  emit       = 1'b1;
                  printed_in = 1'b1;
                  if (neg_ff) begin
                     // The sign goes out first; the same position is visited again for its digit.
                     emit_char = CH_MINUS;
                     neg_in    = 1'b0;
                  end else begin
                     emit_char = dig_char;
                     pos_in    = pos_ff - 1'b1;
                     if (!hex_ff) begin
                        val_in = VAL_BITS'(dec_v - dec_sub);
                     end
                     if (pos_ff == POS_BITS'(1)) begin
                        emit_last = 1'b1;
                        done      = 1'b1;
                     end
                  end
               end else if (pos_ff == POS_BITS'(1)) begin
                  emit      = 1'b1;
                  emit_char = CH_ZERO;
                  emit_last = 1'b1;
                  done      = 1'b1;
                  pos_in    = pos_ff - 1'b1;
               end else begin
                  if (WCMP'(pos_ff) <= WCMP'(width_ff)) begin
                     emit = 1'b1;
                     if (neg_ff && (zpad_ff || next_nz)) begin
                        emit_char = CH_MINUS;
                        neg_in    = 1'b0;
                     end else begin
                        emit_char = zpad_ff ? CH_ZERO : CH_SPACE;
                     end
                  end
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (out_en && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pos_ff       <= '0;
         neg_ff       <= 1'b0;
         printed_ff   <= 1'b0;
         hex_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         printed_ff   <= printed_in;
         hex_ff       <= hex_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      upper_ff <= upper_in;
      zpad_ff  <= zpad_in;
      width_ff <= width_in;
      if (out_en && emit) begin
         out_char_ff <= emit_char;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   `PIF_ASSERT(a_run_pos, (state_ff == BK_RUN) |-> (pos_ff != '0), "walker passed the last position")
   `PIF_NEVER(a_neg_hex, neg_ff && hex_ff, "sign pending on a hex conversion")
   `PIF_ASSERT(a_last_idle, (out_en && emit && emit_last) |=> (state_ff == BK_IDLE), "walker busy after final character")
   `PIF_NEVER(a_pop_busy, q_pop && (state_ff == BK_RUN), "command taken while a conversion runs")

endmodule
